// File: hw/rtl/rrc_pkg.sv
// Shared constants, types and the CRC-16 byte step for the Modbus RTU reply checker.
package rrc_pkg;

    localparam int FRAME_BYTES_DEF = 64;
    localparam int MIN_REPLY       = 5;
    localparam int EXC_BIT         = 7;
    localparam int WRITE_BYTES     = 4;
    localparam int MAX_WORDS       = 31;
    localparam int WCNT_W          = 5;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    localparam logic [7:0] ADDR_RESET = 8'd1;
    localparam logic [6:0] FUNC_RESET = 7'd3;

    // configuration register indexes
    localparam logic REG_EXP_ADDR = 1'b0;
    localparam logic REG_EXP_FUNC = 1'b1;

    // result kinds
    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_ADDRESS    = 3'd2;
    localparam logic [2:0] ST_FUNCTION   = 3'd3;
    localparam logic [2:0] ST_CRC        = 3'd4;
    localparam logic [2:0] ST_INCOMPLETE = 3'd5;
    localparam logic [2:0] ST_EXCEPTION  = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_HI,
        S_RD_LO,
        S_WORD,
        S_STATUS
    } t_state;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/rrc_store.sv
// Frame byte store: one write port, one registered read port.
module rrc_store #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/modbus_rtu_reply_checker.sv
// Top level of the Modbus RTU reply checker: capture, CRC, verdict and word readout.
//
//   channel | valid       | stall       | payload
//   in      | i_in_valid  | o_in_stall  | i_rx_byte, i_byte_valid, i_frame_end
//   out     | o_out_valid | i_out_stall | o_item_kind, o_register_word, o_status,
//           |             |             | o_exception_code, o_last
//   cfg     | i_cfg_we    | -           | i_cfg_index, i_cfg_data
//
// A request without frame end is accepted directly; a new request can be taken every cycle while
// o_in_stall is low. At frame end the verdict is formed in the accepting cycle; each register
// word then passes S_RD_HI, S_RD_LO and S_WORD (two reads of the single store read port and one
// output load), and the status item S_STATUS; both load states wait while the output is stalled.
// o_in_stall is high after the frame end request is accepted until the status item is loaded.
// Reset is synchronous; the byte store needs no clearing, bytes past the length read as zero.
module modbus_rtu_reply_checker
    import rrc_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_byte_valid,
    input  logic        i_frame_end,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_item_kind,
    output logic [15:0] o_register_word,
    output logic [2:0]  o_status,
    output logic [7:0]  o_exception_code,
    output logic        o_last,

    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int CW = $clog2(FRAME_BYTES + 2);
    localparam int AW = $clog2(FRAME_BYTES);

    t_state r_state, n_state;

    logic [CW-1:0]     r_len, n_len;
    logic [15:0]       r_crc, n_crc;
    logic [15:0]       r_hold, n_hold;
    logic [1:0]        r_hcnt, n_hcnt;
    logic [7:0]        r_b0, r_b1, r_b2;
    logic [7:0]        r_exp_addr;
    logic [6:0]        r_exp_func;
    logic [CW-1:0]     r_ptr;
    logic [CW-1:0]     r_end;
    logic [WCNT_W-1:0] r_nw;
    logic [7:0]        r_hi;
    logic [2:0]        r_st;
    logic [7:0]        r_exc;

    logic        r_out_valid;
    logic        r_out_kind;
    logic [15:0] r_out_word;
    logic [2:0]  r_out_status;
    logic [7:0]  r_out_exc;
    logic        r_out_last;

    logic          w_acc, w_wr, w_end, w_free;
    logic          w_ld_word, w_ld_stat, w_more, w_words;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_rdata, w_lo;
    logic [CW-1:0] w_ptr1, w_ptr2;

    logic [15:0] v_rx_crc;
    logic [2:0]  v_st;
    logic [7:0]  v_exc;
    logic [1:0]  v_start;
    logic [7:0]  v_cnt;
    logic [8:0]  v_sum;

    rrc_store #(
        .DEPTH (FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_wr),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // byte capture and CRC with a two-byte holdback
    assign w_acc = i_in_valid && !o_in_stall;
    assign w_wr  = w_acc && i_byte_valid && (r_len < CW'(FRAME_BYTES));
    assign w_end = w_acc && i_frame_end;

    always_comb begin
        n_len  = r_len;
        n_crc  = r_crc;
        n_hold = r_hold;
        n_hcnt = r_hcnt;
        if (w_wr) begin
            n_len  = r_len + CW'(1);
            n_hold = {r_hold[7:0], i_rx_byte};
            if (r_hcnt >= 2'd2) begin
                n_crc = crc_byte(r_crc, r_hold[15:8]);
            end else begin
                n_hcnt = r_hcnt + 2'd1;
            end
        end
    end

    // frame verdict; header bytes are already latched whenever the length passes the minimum
    always_comb begin
        v_rx_crc = {n_hold[7:0], n_hold[15:8]};
        v_exc    = 8'h00;
        v_start  = 2'd2;
        v_cnt    = 8'(WRITE_BYTES);
        if (r_exp_func inside {[7'd1:7'd4]}) begin
            v_start = 2'd3;
            v_cnt   = r_b2;
        end
        v_sum = 9'(v_cnt) + 9'(v_start);
        if (n_len < CW'(MIN_REPLY)) begin
            v_st = ST_SHORT;
        end else if (r_b0 != r_exp_addr) begin
            v_st = ST_ADDRESS;
        end else if (r_b1[6:0] != r_exp_func) begin
            v_st = ST_FUNCTION;
        end else if (v_rx_crc != n_crc) begin
            v_st = ST_CRC;
        end else if (r_b1[EXC_BIT]) begin
            v_st  = ST_EXCEPTION;
            v_exc = r_b2;
        end else if (v_sum > 9'(n_len)) begin
            v_st = ST_INCOMPLETE;
        end else begin
            v_st = ST_OK;
        end
        w_words = (v_st == ST_OK) && (v_cnt != 8'd0);
    end

    // word readout
    assign w_free = !r_out_valid || !i_out_stall;
    assign w_ptr1 = r_ptr + CW'(1);
    assign w_ptr2 = r_ptr + CW'(2);
    assign w_lo   = (w_ptr1 < r_len) ? w_rdata : 8'h00;
    assign w_more = (w_ptr2 < r_end) && (r_nw < WCNT_W'(MAX_WORDS - 1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_end) begin
                    n_state = w_words ? S_RD_HI : S_STATUS;
                end
            end
            S_RD_HI: n_state = S_RD_LO;
            S_RD_LO: n_state = S_WORD;
            S_WORD: begin
                if (w_free) begin
                    n_state = w_more ? S_RD_HI : S_STATUS;
                end
            end
            S_STATUS: begin
                if (w_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_raddr    = (r_state == S_RD_HI) ? r_ptr[AW-1:0] : w_ptr1[AW-1:0];
        w_ld_word  = (r_state == S_WORD) && w_free;
        w_ld_stat  = (r_state == S_STATUS) && w_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_len      <= '0;
            r_crc      <= CRC_INIT;
            r_hold     <= '0;
            r_hcnt     <= '0;
            r_exp_addr <= ADDR_RESET;
            r_exp_func <= FUNC_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_EXP_ADDR: r_exp_addr <= i_cfg_data;
                    REG_EXP_FUNC: r_exp_func <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
            if (w_end) begin
                // keep the length for the readout, restart the CRC
                r_len  <= n_len;
                r_crc  <= CRC_INIT;
                r_hold <= '0;
                r_hcnt <= '0;
            end else if (w_ld_stat) begin
                r_len <= '0;
            end else begin
                r_len  <= n_len;
                r_crc  <= n_crc;
                r_hold <= n_hold;
                r_hcnt <= n_hcnt;
            end
        end
    end

    // header bytes and readout context
    always_ff @(posedge i_clk) begin
        if (w_wr && (r_len == CW'(0))) begin
            r_b0 <= i_rx_byte;
        end
        if (w_wr && (r_len == CW'(1))) begin
            r_b1 <= i_rx_byte;
        end
        if (w_wr && (r_len == CW'(2))) begin
            r_b2 <= i_rx_byte;
        end
        if (w_end) begin
            r_ptr <= CW'(v_start);
            r_end <= CW'(v_sum);
            r_nw  <= '0;
            r_st  <= v_st;
            r_exc <= v_exc;
        end else if (w_ld_word) begin
            r_ptr <= w_ptr2;
            r_nw  <= r_nw + WCNT_W'(1);
        end
        if (r_state == S_RD_LO) begin
            r_hi <= w_rdata;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ld_word || w_ld_stat) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_word) begin
            r_out_kind   <= KIND_WORD;
            r_out_word   <= {r_hi, w_lo};
            r_out_status <= ST_OK;
            r_out_exc    <= 8'h00;
            r_out_last   <= 1'b0;
        end else if (w_ld_stat) begin
            r_out_kind   <= KIND_STATUS;
            r_out_word   <= 16'h0000;
            r_out_status <= r_st;
            r_out_exc    <= r_exc;
            r_out_last   <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_item_kind      = r_out_kind;
    assign o_register_word  = r_out_word;
    assign o_status         = r_out_status;
    assign o_exception_code = r_out_exc;
    assign o_last           = r_out_last;

endmodule
